### src/clps_pkg.sv
// Shared types and constants for the percent-clip linear stretch block.
// No dependencies.
package clps_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_RANK_GO,
        ST_RANK_WAIT,
        ST_WALK,
        ST_WALK_TAIL,
        ST_MAP_CHK,
        ST_MAP_WAIT
    } clps_state_t;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_MAP   = 1'b1;
    localparam logic [7:0] OUT_MAX  = 8'd255;
    localparam logic [7:0] OUT_MIN  = 8'd0;
    localparam logic [6:0] PCT_FULL = 7'd100;

    // floor(x / 100) taken as (x * RANK_RECIP) >> RANK_SHIFT, exact for x below 2^32
    localparam logic [31:0] RANK_RECIP = 32'd2748779070;
    localparam int          RANK_SHIFT = 38;

endpackage

### src/clps_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module clps_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

### src/percent_clip_linear_stretch_top.sv
// Top level of the percent-clip linear stretch: histogram memory, level search, mapping.
// Depends on clps_pkg and clps_div.
//
// Usage:
//   A transaction is taken at a clock edge with start high and busy low.
//   op = load adds pixel to the histogram (memory read, then write back); once MAX_PIXELS
//   pixels are counted, a load adds nothing. A load with last then works out the two
//   ranks by reciprocal multiplication (ST_RANK_GO, then ST_RANK_WAIT) and walks the
//   whole histogram, one bin per cycle, clearing it.
//   op = map gives one result on out_pixel with out_valid high for one cycle: straight
//   from ST_MAP_CHK when the pixel is clipped, else once the bit-serial divider
//   is done.
//   The receiver cannot stall; each result is shown exactly once.
//   After reset the block clears the histogram memory, one bin per cycle, with busy
//   high. clip_percent resets to 2 and may be written through cfg_wr_en / cfg_wr_data
//   at any time the block is idle.
module percent_clip_linear_stretch_top
    import clps_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int MAX_PIXELS = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] pixel,
    input  logic        last,
    output logic        out_valid,
    output logic [7:0]  out_pixel,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data
);
    localparam int PB      = PIXEL_BITS;
    localparam int DEPTH   = 1 << PB;
    localparam int CW      = $clog2(MAX_PIXELS + 1);
    localparam int RNUM_W  = CW + 7;
    localparam int RPROD_W = RNUM_W + 32;
    localparam int MNUM_W  = PB + 8;

    clps_state_t state_reg, state_next;

    logic [CW-1:0]    mem [DEPTH];
    logic [CW-1:0]    rdata_reg;
    logic             we, re;
    logic [PB-1:0]    waddr, raddr;
    logic [CW-1:0]    wdata;

    logic [5:0]       clip_reg;
    logic [CW-1:0]    count_reg;
    logic [PB-1:0]    low_reg, high_reg;
    logic [PB-1:0]    pix_reg;
    logic             last_reg;
    logic [PB-1:0]    addr_reg;
    logic [PB-1:0]    daddr_reg;
    logic             dv_reg;
    logic [CW-1:0]    cum_reg;
    logic             lo_found_reg, hi_found_reg;
    logic [CW-1:0]    rlo_reg, rhi_reg;
    logic [RNUM_W-1:0] rnum_lo_reg, rnum_hi_reg;
    logic             out_valid_reg;
    logic [7:0]       out_pixel_reg;

    logic             accept;
    logic             count_full;
    logic             map_go;
    logic [RNUM_W-1:0] rnum_lo, rnum_hi;
    logic [RPROD_W-1:0] rprod_lo, rprod_hi;
    logic [CW-1:0]    rq_lo, rq_hi;
    logic [MNUM_W-1:0] mnum, mq;
    logic             mdone;
    logic [PB-1:0]    mden;
    logic [CW-1:0]    cum_new;
    logic [CW-1:0]    rlo_c, rhi_c;
    logic             map_hi, map_lo;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = state_reg != ST_IDLE;
    assign count_full = count_reg >= CW'(MAX_PIXELS);
    assign cum_new    = cum_reg + rdata_reg;
    assign map_hi     = pix_reg >= high_reg;
    assign map_lo     = pix_reg <= low_reg;

    assign rnum_lo  = RNUM_W'(count_reg) * RNUM_W'(clip_reg);
    assign rnum_hi  = RNUM_W'(count_reg) * RNUM_W'(PCT_FULL - {1'b0, clip_reg});
    assign rprod_lo = RPROD_W'(rnum_lo_reg) * RPROD_W'(RANK_RECIP);
    assign rprod_hi = RPROD_W'(rnum_hi_reg) * RPROD_W'(RANK_RECIP);
    assign rq_lo    = rprod_lo[RANK_SHIFT +: CW];
    assign rq_hi    = rprod_hi[RANK_SHIFT +: CW];
    assign mnum     = MNUM_W'(pix_reg - low_reg) * MNUM_W'(OUT_MAX);
    assign mden     = high_reg - low_reg;
    assign rlo_c    = (rq_lo == '0) ? CW'(1) : rq_lo;
    assign rhi_c    = (rq_hi == '0) ? CW'(1) : rq_hi;

    clps_div #(.NUM_W(MNUM_W), .DEN_W(PB)) u_div_map (
        .clk(clk), .rst_n(rst_n), .go(map_go), .num(mnum), .den(mden),
        .done(mdone), .quot(mq)
    );

    // Histogram memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == PB'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_MAP)
                    begin
                        state_next = ST_MAP_CHK;
                    end
                    else if (!count_full)
                    begin
                        state_next = ST_LOAD_RD;
                    end
                    else if (last)
                    begin
                        state_next = ST_RANK_GO;
                    end
                end
            end
            ST_LOAD_RD:   state_next = ST_LOAD_WR;
            ST_LOAD_WR:   state_next = last_reg ? ST_RANK_GO : ST_IDLE;
            ST_RANK_GO:   state_next = ST_RANK_WAIT;
            ST_RANK_WAIT: state_next = ST_WALK;
            ST_WALK:
            begin
                if (addr_reg == PB'(DEPTH - 1))
                begin
                    state_next = ST_WALK_TAIL;
                end
            end
            ST_WALK_TAIL: state_next = ST_IDLE;
            ST_MAP_CHK:   state_next = (map_hi || map_lo) ? ST_IDLE : ST_MAP_WAIT;
            ST_MAP_WAIT:
            begin
                if (mdone)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory and divider control
    always_comb
    begin
        we      = 1'b0;
        re      = 1'b0;
        waddr   = addr_reg;
        raddr   = addr_reg;
        wdata   = '0;
        map_go  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
            end
            ST_LOAD_RD:
            begin
                re    = 1'b1;
                raddr = pix_reg;
            end
            ST_LOAD_WR:
            begin
                we    = 1'b1;
                waddr = pix_reg;
                wdata = rdata_reg + 1'b1;
            end
            ST_WALK, ST_WALK_TAIL:
            begin
                re    = state_reg == ST_WALK;
                we    = dv_reg;
                waddr = daddr_reg;
            end
            ST_MAP_CHK:
            begin
                map_go = !(map_hi || map_lo);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clip_reg      <= 6'd2;
            count_reg     <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            addr_reg      <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b0;
            dv_reg        <= state_reg == ST_WALK;
            if (cfg_wr_en)
            begin
                clip_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR || state_reg == ST_WALK)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (state_reg == ST_LOAD_WR)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_RANK_WAIT)
            begin
                low_reg  <= '0;
                high_reg <= '0;
            end
            if (dv_reg)
            begin
                if (!lo_found_reg && cum_new >= rlo_reg)
                begin
                    low_reg <= daddr_reg;
                end
                if (!hi_found_reg && cum_new >= rhi_reg)
                begin
                    high_reg <= daddr_reg;
                end
            end
            if (state_reg == ST_WALK_TAIL)
            begin
                count_reg <= '0;
            end
            if (state_reg == ST_MAP_CHK && (map_hi || map_lo))
            begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == ST_MAP_WAIT && mdone)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pixel[PB-1:0];
            last_reg <= last;
        end
        daddr_reg <= addr_reg;
        // hold the rank numerators in registers so the reciprocal multiply is split from the numerator multiply
        if (state_reg == ST_RANK_GO)
        begin
            rnum_lo_reg <= rnum_lo;
            rnum_hi_reg <= rnum_hi;
        end
        if (state_reg == ST_RANK_WAIT)
        begin
            rlo_reg      <= rlo_c;
            rhi_reg      <= rhi_c;
            cum_reg      <= '0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
        end
        else if (dv_reg)
        begin
            cum_reg <= cum_new;
            if (cum_new >= rlo_reg)
            begin
                lo_found_reg <= 1'b1;
            end
            if (cum_new >= rhi_reg)
            begin
                hi_found_reg <= 1'b1;
            end
        end
        if (state_reg == ST_MAP_CHK)
        begin
            out_pixel_reg <= map_hi ? OUT_MAX : OUT_MIN;
        end
        else if (state_reg == ST_MAP_WAIT && mdone)
        begin
            out_pixel_reg <= mq[7:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
endmodule
